### src/csrspmv_pkg.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// csrspmv_pkg: shared types and constants of the CSR sparse matrix-vector unit
// Holds the request codes, the vector store geometry and the queue entry type
// that passes between the front and the back of the block.
// ----------------------------------------------------------------------------
package csrspmv_pkg;

  // Request codes carried in the input tuser field.
  localparam logic [1:0] CMD_LOAD    = 2'd0;
  localparam logic [1:0] CMD_NONZERO = 2'd1;
  localparam logic [1:0] CMD_END_ROW = 2'd2;

  // Field widths of the streams.
  localparam int IDX_W   = 10;
  localparam int VAL_W   = 32;
  localparam int ACC_W   = 48;
  localparam int PROD_W  = 2 * VAL_W;
  localparam int FRAC_W  = 16;
  localparam int S_DATA_W = 48;
  localparam int M_DATA_W = 32;

  // Vector store geometry.
  localparam int VEC_DEPTH = 1024;
  localparam int VEC_AW    = (VEC_DEPTH > 1) ? $clog2(VEC_DEPTH) : 1;

  // Queue between front and back.
  localparam int Q_DEPTH = 4;
  localparam int Q_AW    = $clog2(Q_DEPTH);
  localparam int Q_CW    = $clog2(Q_DEPTH + 1);

  // One classified request on its way to the multiply-accumulate back end.
  typedef struct packed {
    logic                    is_end;
    logic signed [VAL_W-1:0] value;
    logic signed [VAL_W-1:0] x;
  } spmv_item_t;

endpackage
`default_nettype wire

### src/csr_sparse_matrix_vector_multiply.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// csr_sparse_matrix_vector_multiply: streaming y = A*x for a CSR matrix
// Requests on the slave stream load vector elements, feed nonzeros and close
// rows; each closed row yields one Q16.16 sum on the master stream.
//
// Usage: s_tuser selects the request: load writes value at index into the
// vector store, nonzero multiplies value by the stored element at column
// index and adds it to the row sum, row end emits the sum and clears it.
// Code three is ignored. A nonzero may only name a column loaded before.
// Throughput: one request per cycle while s_tready is high. A row end
// reaches m_tvalid through the vector RAM read and its stage register, the
// queue, the product register and the output register.
// Reset clears the pipeline, the queue, the accumulator and the flag; the
// vector store keeps whatever it holds. When the receiver stalls, the
// output register holds the result, the four-entry queue fills up, and
// then s_tready drops; loads and nonzeros keep flowing while room is left.
// ----------------------------------------------------------------------------
module csr_sparse_matrix_vector_multiply
  import csrspmv_pkg::*;
(
  input  wire logic                clk,
  input  wire logic                rst,
  input  wire logic                s_tvalid,
  output logic                     s_tready,
  input  wire logic [S_DATA_W-1:0] s_tdata,  // index[9:0], value[41:10], zero pad
  input  wire logic [1:0]          s_tuser,  // cmd[1:0]
  output logic                     m_tvalid,
  input  wire logic                m_tready,
  output logic [M_DATA_W-1:0]      m_tdata,  // row_sum[31:0]
  output logic [0:0]               m_tuser   // saturated[0]
);

  logic       push;
  spmv_item_t push_item;
  logic       full;
  logic       pop;
  spmv_item_t pop_item;
  logic       empty;

  // Front end: intake and vector store.
  csrspmv_front u_front (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),
    .s_tuser  (s_tuser),
    .push     (push),
    .push_item(push_item),
    .full     (full)
  );

  // Decoupling queue.
  csrspmv_fifo u_fifo (
    .clk      (clk),
    .rst      (rst),
    .push     (push),
    .push_item(push_item),
    .full     (full),
    .pop      (pop),
    .pop_item (pop_item),
    .empty    (empty)
  );

  // Back end: multiply-accumulate and output.
  csrspmv_back u_back (
    .clk     (clk),
    .rst     (rst),
    .pop_item(pop_item),
    .empty   (empty),
    .pop     (pop),
    .m_tvalid(m_tvalid),
    .m_tready(m_tready),
    .m_tdata (m_tdata),
    .m_tuser (m_tuser)
  );

endmodule
`default_nettype wire

### src/csrspmv_ram.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// csrspmv_ram: generic single-port-write, single-port-read RAM
// One write and one registered read per cycle; read data holds when idle.
// ----------------------------------------------------------------------------
module csrspmv_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 1024
) (
  input  wire logic                                  clk,
  input  wire logic                                  we,
  input  wire logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
  input  wire logic [WIDTH-1:0]                      wdata,
  input  wire logic                                  re,
  input  wire logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
  output logic      [WIDTH-1:0]                      rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // Write port and registered read port.
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule
`default_nettype wire

### src/csrspmv_front.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// csrspmv_front: request intake, vector store access and classification
// Loads write the vector store; nonzeros read it; nonzeros and row ends are
// passed on to the queue together with the vector element that was read.
// ----------------------------------------------------------------------------
module csrspmv_front
  import csrspmv_pkg::*;
(
  input  wire logic                clk,
  input  wire logic                rst,
  input  wire logic                s_tvalid,
  output logic                     s_tready,
  input  wire logic [S_DATA_W-1:0] s_tdata,
  input  wire logic [1:0]          s_tuser,
  output logic                     push,
  output spmv_item_t               push_item,
  input  wire logic                full
);

  logic [IDX_W-1:0]        index;
  logic signed [VAL_W-1:0] value;
  logic [31:0]             idx_wide;
  logic                    in_range;
  logic [VEC_AW-1:0]       addr;
  logic                    accept;
  logic                    ram_we;
  logic                    ram_re;
  logic                    fwd;
  logic [VAL_W-1:0]        ram_rdata;

  logic                    s1_valid;
  logic                    s1_is_end;
  logic                    s1_in_range;
  logic signed [VAL_W-1:0] s1_value;

  assign index    = s_tdata[IDX_W-1:0];
  assign value    = s_tdata[IDX_W+VAL_W-1:IDX_W];
  assign idx_wide = 32'(index);
  assign in_range = idx_wide < 32'(VEC_DEPTH);
  assign addr     = VEC_AW'(idx_wide);

  // The stage register moves whenever it is empty or the queue has room.
  assign s_tready = !s1_valid || !full;
  assign accept   = s_tvalid && s_tready;

  // Classify the request by its code.
  always_comb begin
    ram_we = 1'b0;
    ram_re = 1'b0;
    fwd    = 1'b0;
    case (s_tuser)
      CMD_LOAD: begin
        ram_we = accept && in_range;
      end
      CMD_NONZERO: begin
        ram_re = accept;
        fwd    = accept;
      end
      CMD_END_ROW: begin
        fwd = accept;
      end
      default: begin
        fwd = 1'b0;
      end
    endcase
  end

  csrspmv_ram #(
    .WIDTH(VAL_W),
    .DEPTH(VEC_DEPTH)
  ) u_vec_ram (
    .clk  (clk),
    .we   (ram_we),
    .waddr(addr),
    .wdata(value),
    .re   (ram_re),
    .raddr(addr),
    .rdata(ram_rdata)
  );

  // Stage register that lines up with the registered RAM read.
  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (s_tready) begin
      s1_valid <= fwd;
    end
    if (accept) begin
      s1_is_end   <= (s_tuser == CMD_END_ROW);
      s1_in_range <= in_range;
      s1_value    <= value;
    end
  end

  // A row end or an out-of-range column carries a zero vector element.
  assign push             = s1_valid && !full;
  assign push_item.is_end = s1_is_end;
  assign push_item.value  = s1_value;
  assign push_item.x      = (s1_is_end || !s1_in_range) ? '0 : ram_rdata;

endmodule
`default_nettype wire

### src/csrspmv_fifo.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// csrspmv_fifo: short request queue between front and back
// A small circular buffer of classified requests with a fill count.
// ----------------------------------------------------------------------------
module csrspmv_fifo
  import csrspmv_pkg::*;
(
  input  wire logic       clk,
  input  wire logic       rst,
  input  wire logic       push,
  input  wire spmv_item_t push_item,
  output logic            full,
  input  wire logic       pop,
  output spmv_item_t      pop_item,
  output logic            empty
);

  spmv_item_t      entries [Q_DEPTH];
  logic [Q_AW-1:0] wr_ptr;
  logic [Q_AW-1:0] rd_ptr;
  logic [Q_CW-1:0] count;

  assign full     = count == Q_CW'(Q_DEPTH);
  assign empty    = count == '0;
  assign pop_item = entries[rd_ptr];

  // Pointers and fill count.
  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= (wr_ptr == Q_AW'(Q_DEPTH - 1)) ? '0 : wr_ptr + 1'b1;
      end
      if (pop) begin
        rd_ptr <= (rd_ptr == Q_AW'(Q_DEPTH - 1)) ? '0 : rd_ptr + 1'b1;
      end
      if (push && !pop) begin
        count <= count + 1'b1;
      end else if (pop && !push) begin
        count <= count - 1'b1;
      end
    end
  end

  // Entry storage.
  always_ff @(posedge clk) begin
    if (push) begin
      entries[wr_ptr] <= push_item;
    end
  end

`ifndef SYNTHESIS
  a_no_overrun: assert property (@(posedge clk) disable iff (rst)
    !(push && full) && !(pop && empty))
    else $error("queue pushed while full or popped while empty");
  a_count_up: assert property (@(posedge clk) disable iff (rst)
    push && !pop |=> count == $past(count) + 1'b1)
    else $error("queue count did not follow a lone push");
`endif

endmodule
`default_nettype wire

### src/csrspmv_back.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// csrspmv_back: multiply, row accumulation and result output
// A product stage followed by a saturating 48-bit accumulator; a row end
// clamps the sum to 32 bits and loads the output register.
// ----------------------------------------------------------------------------
module csrspmv_back
  import csrspmv_pkg::*;
(
  input  wire logic                clk,
  input  wire logic                rst,
  input  wire spmv_item_t          pop_item,
  input  wire logic                empty,
  output logic                     pop,
  output logic                     m_tvalid,
  input  wire logic                m_tready,
  output logic [M_DATA_W-1:0]      m_tdata,
  output logic [0:0]               m_tuser
);

  logic                     mv;
  logic                     m_is_end;
  logic signed [PROD_W-1:0] prod;
  logic                     out_free;
  logic                     m_adv;
  logic                     emit;

  logic signed [ACC_W-1:0]  acc;
  logic                     ovf;
  logic [ACC_W-1:0]         prod_trunc;
  logic [ACC_W:0]           sum;
  logic                     sum_sat;
  logic [ACC_W-1:0]         acc_next;
  logic                     fits32;
  logic [M_DATA_W-1:0]      row_sum;

  // Flow control: the product stage drains unless a row end meets a full output.
  assign out_free = !m_tvalid || m_tready;
  assign m_adv    = mv && (!m_is_end || out_free);
  assign pop      = !empty && (!mv || m_adv);
  assign emit     = m_adv && m_is_end;

  // Product stage.
  always_ff @(posedge clk) begin
    if (rst) begin
      mv <= 1'b0;
    end else if (!mv || m_adv) begin
      mv <= !empty;
    end
    if (pop) begin
      m_is_end <= pop_item.is_end;
      prod     <= pop_item.value * pop_item.x;
    end
  end

  // Truncate Q32.32 to Q32.16 and add with saturation at 48 bits.
  assign prod_trunc = prod[PROD_W-1:FRAC_W];
  assign sum        = {acc[ACC_W-1], acc} + {prod_trunc[ACC_W-1], prod_trunc};
  assign sum_sat    = sum[ACC_W] != sum[ACC_W-1];
  always_comb begin
    if (!sum_sat) begin
      acc_next = sum[ACC_W-1:0];
    end else if (sum[ACC_W]) begin
      acc_next = {1'b1, {(ACC_W-1){1'b0}}};
    end else begin
      acc_next = {1'b0, {(ACC_W-1){1'b1}}};
    end
  end

  // Clamp the row sum to the 32-bit range.
  assign fits32  = (&acc[ACC_W-1:M_DATA_W-1]) || !(|acc[ACC_W-1:M_DATA_W-1]);
  assign row_sum = fits32 ? acc[M_DATA_W-1:0]
                 : (acc[ACC_W-1] ? {1'b1, {(M_DATA_W-1){1'b0}}}
                                 : {1'b0, {(M_DATA_W-1){1'b1}}});

  // Accumulator, overflow flag and output register.
  always_ff @(posedge clk) begin
    if (rst) begin
      acc      <= '0;
      ovf      <= 1'b0;
      m_tvalid <= 1'b0;
    end else begin
      if (emit) begin
        acc      <= '0;
        ovf      <= 1'b0;
        m_tvalid <= 1'b1;
      end else begin
        if (m_adv) begin
          acc <= acc_next;
          ovf <= ovf || sum_sat;
        end
        if (m_tready) begin
          m_tvalid <= 1'b0;
        end
      end
    end
    if (emit) begin
      m_tdata    <= row_sum;
      m_tuser[0] <= ovf || !fits32;
    end
  end

`ifndef SYNTHESIS
  a_row_clear: assert property (@(posedge clk) disable iff (rst)
    emit |=> acc == '0 && !ovf)
    else $error("accumulator not cleared after a row end");
  a_prod_hold: assert property (@(posedge clk) disable iff (rst)
    mv && !m_adv |=> mv && $stable(prod) && $stable(m_is_end))
    else $error("stalled product stage changed");
`endif

endmodule
`default_nettype wire
